// ----- src/nonpreemptive_sjf_scheduler_assert.svh -----
// Assertion macros used by the scheduler datapath.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef NONPREEMPTIVE_SJF_SCHEDULER_ASSERT_SVH
`define NONPREEMPTIVE_SJF_SCHEDULER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define NSJF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its trigger.
`define NSJF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that holds in the cycle after its trigger.
`define NSJF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/nsjf_pkg.sv -----
package nsjf_pkg;

  localparam int DATA_W = 16;
  localparam int TIME_W = 21;
  localparam int ID_W   = 5;

  typedef struct packed {
    logic [DATA_W-1:0] burst_time;
    logic [DATA_W-1:0] arrival_time;
    logic              last_job;
  } job_t;

  typedef struct packed {
    logic [ID_W-1:0]   job_id;
    logic [DATA_W-1:0] job_burst;
    logic [DATA_W-1:0] job_arrival;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] turnaround_time;
    logic              last_result;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_start;
    logic calc;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
    logic batch_last;
  } dp_status_t;

endpackage

// ----- src/nsjf_datapath.sv -----
`include "nonpreemptive_sjf_scheduler_assert.svh"

module nsjf_datapath import nsjf_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  job_t       job,
  output result_t    result,
  output logic       result_valid,
  input  logic       result_ready
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_JOBS);

  // Job store.
  logic [DATA_W-1:0] burst_mem   [MAX_JOBS];
  logic [DATA_W-1:0] arrival_mem [MAX_JOBS];

  logic [MAX_JOBS-1:0] done_flags;
  logic [CNT_W-1:0]    job_count;
  logic [CNT_W-1:0]    pick_count;
  logic [TIME_W-1:0]   cur_time;

  // Scan pipeline: address issue, then registered read data.
  logic              issuing;
  logic [IDX_W-1:0]  scan_idx;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic [DATA_W-1:0] rd_burst;
  logic [DATA_W-1:0] rd_arrival;

  // Best ready job and best pending job found so far in this scan.
  logic              rfound;
  logic [IDX_W-1:0]  rbest_idx;
  logic [DATA_W-1:0] rbest_burst;
  logic [DATA_W-1:0] rbest_arr;
  logic              pfound;
  logic [IDX_W-1:0]  pbest_idx;
  logic [DATA_W-1:0] pbest_burst;
  logic [DATA_W-1:0] pbest_arr;

  // The chosen job.
  logic [IDX_W-1:0]  pick_idx;
  logic [DATA_W-1:0] pick_burst;
  logic [DATA_W-1:0] pick_arr;
  logic [TIME_W-1:0] pick_start;
  logic [TIME_W-1:0] pick_wait;

  logic              rd_done;
  logic              ready_hit;
  logic              pend_hit;
  logic [TIME_W:0]   tat_sum;
  logic [TIME_W:0]   time_sum;
  logic [TIME_W-1:0] tat_sat;
  logic [TIME_W-1:0] time_sat;
  logic [IDX_W:0]    id_sum;

  assign rd_done = done_flags[rd_idx];

  assign ready_hit = !rd_done && (TIME_W'(rd_arrival) <= cur_time) &&
                     (!rfound || (rd_burst < rbest_burst));

  // Used only when nothing is ready: the earliest arrival wins, and among
  // jobs that arrive together the shortest one, loaded first on a tie.
  assign pend_hit = !rd_done &&
                    (!pfound || (rd_arrival < pbest_arr) ||
                     ((rd_arrival == pbest_arr) && (rd_burst < pbest_burst)));

  assign tat_sum  = {1'b0, pick_wait} + (TIME_W + 1)'(pick_burst);
  assign time_sum = {1'b0, pick_start} + (TIME_W + 1)'(pick_burst);
  assign tat_sat  = tat_sum[TIME_W] ? '1 : tat_sum[TIME_W-1:0];
  assign time_sat = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
  assign id_sum   = {1'b0, pick_idx} + (IDX_W + 1)'(1);

  assign status.scan_done  = rd_vld && (CNT_W'(rd_idx) == job_count - CNT_W'(1));
  assign status.out_free   = !result_valid || result_ready;
  assign status.batch_last = (pick_count == job_count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load && (job_count < FULL)) begin
      burst_mem[job_count[IDX_W-1:0]]   <= job.burst_time;
      arrival_mem[job_count[IDX_W-1:0]] <= job.arrival_time;
    end
    rd_burst   <= burst_mem[scan_idx];
    rd_arrival <= arrival_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      scan_idx <= '0;
      rd_vld   <= 1'b0;
      rfound   <= 1'b0;
      pfound   <= 1'b0;
    end else begin
      rd_vld <= issuing;
      rd_idx <= scan_idx;
      if (cmd.scan_start) begin
        issuing  <= 1'b1;
        scan_idx <= '0;
        rfound   <= 1'b0;
        pfound   <= 1'b0;
      end else begin
        if (issuing) begin
          if (CNT_W'(scan_idx) == job_count - CNT_W'(1)) begin
            issuing <= 1'b0;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        if (rd_vld && ready_hit) begin
          rfound      <= 1'b1;
          rbest_idx   <= rd_idx;
          rbest_burst <= rd_burst;
          rbest_arr   <= rd_arrival;
        end
        if (rd_vld && pend_hit) begin
          pfound      <= 1'b1;
          pbest_idx   <= rd_idx;
          pbest_burst <= rd_burst;
          pbest_arr   <= rd_arrival;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      if (rfound) begin
        pick_idx   <= rbest_idx;
        pick_burst <= rbest_burst;
        pick_arr   <= rbest_arr;
        pick_start <= cur_time;
        pick_wait  <= cur_time - TIME_W'(rbest_arr);
      end else begin
        // Idle gap: time jumps to the arrival of the chosen job.
        pick_idx   <= pbest_idx;
        pick_burst <= pbest_burst;
        pick_arr   <= pbest_arr;
        pick_start <= TIME_W'(pbest_arr);
        pick_wait  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_flags   <= '0;
      job_count    <= '0;
      pick_count   <= '0;
      cur_time     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.load && (job_count < FULL)) begin
        job_count <= job_count + CNT_W'(1);
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
        if (status.batch_last) begin
          done_flags <= '0;
          job_count  <= '0;
          pick_count <= '0;
          cur_time   <= '0;
        end else begin
          done_flags[pick_idx] <= 1'b1;
          pick_count           <= pick_count + CNT_W'(1);
          cur_time             <= time_sat;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.job_id          <= ID_W'(id_sum);
      result.job_burst       <= pick_burst;
      result.job_arrival     <= pick_arr;
      result.start_time      <= pick_start;
      result.waiting_time    <= pick_wait;
      result.turnaround_time <= tat_sat;
      result.last_result     <= status.batch_last;
    end
  end

  `NSJF_ASSERT_ALWAYS(a_done_tracks_picks, $countones(done_flags) == int'(pick_count), "done flags disagree with pick count")
  `NSJF_ASSERT_IMP(a_emit_into_free_slot, cmd.emit, !result_valid || result_ready, "result overwritten before it was taken")
  `NSJF_ASSERT_IMP(a_calc_has_candidate, cmd.calc, rfound || pfound, "scan ended without any unfinished job")
  `NSJF_ASSERT_NEXT(a_batch_end_clears, cmd.emit && status.batch_last, (cur_time == '0) && (job_count == '0), "batch state not cleared after the last result")

endmodule

// ----- src/nsjf_ctrl.sv -----
module nsjf_ctrl import nsjf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  logic       last_job,
  output logic       job_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_CALC = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign job_ready = (state == ST_LOAD);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    unique case (state)
      ST_LOAD: begin
        cmd.load = job_valid;
        if (job_valid && last_job) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.batch_last) begin
            state_next = ST_LOAD;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/nonpreemptive_sjf_scheduler.sv -----
// Non-preemptive shortest-job-first scheduler.
// Input channel (job_valid, job_ready, job): one job per item, taken one per
// cycle while loading. A job that arrives when MAX_JOBS jobs are stored is
// dropped; the job marked last_job closes the batch and starts scheduling.
// Output channel (result_valid, result_ready, result): one item per job in
// run order, the final one flagged by last_result.
// Each pick scans the stored jobs through the job memory's single read port:
// the reads are issued in order, the read data is registered, then the times
// are computed and the result is emitted.
// While a result waits in the output register the scan for the next pick
// runs; the block stalls only when a new result is ready and the register
// is still full. No jobs are taken while a batch is being scheduled; the
// next batch can load as soon as the last result sits in the register.
// Reset empties the batch and the output register; the job memory keeps
// its contents, which are never used before they are written.
module nonpreemptive_sjf_scheduler import nsjf_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  output logic    job_ready,
  input  job_t    job,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  nsjf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .last_job  (job.last_job),
    .job_ready (job_ready),
    .status    (status),
    .cmd       (cmd)
  );

  nsjf_datapath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .job          (job),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

// ----- bench/sjf_schedule_checker.sv -----
`timescale 1ns / 100ps

module sjf_schedule_checker import nsjf_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  input  logic    job_ready,
  input  job_t    job,
  input  logic    result_valid,
  input  logic    result_ready,
  input  result_t result,
  output int      fail_count,
  output int      pending
);

  localparam int unsigned TIME_SAT = (1 << TIME_W) - 1;

  logic [DATA_W-1:0] held_burst [MAX_JOBS];
  logic [DATA_W-1:0] held_arrival [MAX_JOBS];
  bit                ran [MAX_JOBS];
  int                held_count;
  result_t           run_order [$];
  result_t           want;

  function automatic int unsigned sat_time(int unsigned t);
    return (t > TIME_SAT) ? TIME_SAT : t;
  endfunction

  // Index of the arrived, unfinished job with the smallest burst, or -1.
  // Strict less-than keeps the earlier-loaded job on a tie.
  function automatic int shortest_ready(int unsigned now);
    int best;
    best = -1;
    for (int i = 0; i < held_count; i++)
      if (!ran[i] && held_arrival[i] <= now &&
          (best < 0 || held_burst[i] < held_burst[best]))
        best = i;
    return best;
  endfunction

  task automatic plan_schedule();
    int unsigned now, next_arrival, start, waited;
    int          pick;
    result_t     r;
    now = 0;
    for (int i = 0; i < MAX_JOBS; i++) ran[i] = 1'b0;
    for (int k = 0; k < held_count; k++) begin
      pick = shortest_ready(now);
      if (pick < 0) begin
        // Nothing is ready, so time skips ahead to the next pending arrival.
        next_arrival = TIME_SAT;
        for (int i = 0; i < held_count; i++)
          if (!ran[i] && held_arrival[i] < next_arrival) next_arrival = 32'(held_arrival[i]);
        now = next_arrival;
        pick = shortest_ready(now);
      end
      start = now;
      waited = start - held_arrival[pick];
      r.job_id          = ID_W'(pick + 1);
      r.job_burst       = held_burst[pick];
      r.job_arrival     = held_arrival[pick];
      r.start_time      = TIME_W'(start);
      r.waiting_time    = TIME_W'(waited);
      r.turnaround_time = TIME_W'(sat_time(waited + held_burst[pick]));
      r.last_result     = (k + 1 == held_count);
      run_order.push_back(r);
      now = sat_time(now + held_burst[pick]);
      ran[pick] = 1'b1;
    end
  endtask

  task automatic flag_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val)
      flag_error($sformatf("%s is %0d, expected %0d", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      run_order.delete();
      fail_count = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (run_order.size() == 0) begin
          flag_error("result item arrived with none expected");
        end else begin
          want = run_order.pop_front();
          compare_field("job_id", 32'(result.job_id), 32'(want.job_id));
          compare_field("job_burst", 32'(result.job_burst), 32'(want.job_burst));
          compare_field("job_arrival", 32'(result.job_arrival), 32'(want.job_arrival));
          compare_field("start_time", 32'(result.start_time), 32'(want.start_time));
          compare_field("waiting_time", 32'(result.waiting_time), 32'(want.waiting_time));
          compare_field("turnaround_time", 32'(result.turnaround_time),
                        32'(want.turnaround_time));
          compare_field("last_result", 32'(result.last_result), 32'(want.last_result));
        end
      end
      if (job_valid && job_ready) begin
        // A job offered to a full store is dropped, but its last flag still counts.
        if (held_count < MAX_JOBS) begin
          held_burst[held_count] = job.burst_time;
          held_arrival[held_count] = job.arrival_time;
          held_count++;
        end
        if (job.last_job) begin
          plan_schedule();
          held_count = 0;
        end
      end
    end
    pending <= run_order.size();
  end

endmodule

// ----- bench/tb_nonpreemptive_sjf_scheduler.sv -----
`timescale 1ns / 100ps

module tb_nonpreemptive_sjf_scheduler;
  import nsjf_pkg::*;

  localparam int MAX_JOBS    = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_JOBS  = 95;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    job_valid = 1'b0;
  logic    job_ready;
  job_t    job = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;
  int      fail_count;
  int      pending;

  int send_idle = 0;
  int recv_stall = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int quiet = 0;

  always #10 clk = ~clk;

  nonpreemptive_sjf_scheduler #(
    .MAX_JOBS(MAX_JOBS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job(job),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  sjf_schedule_checker #(
    .MAX_JOBS(MAX_JOBS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job(job),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .fail_count(fail_count),
    .pending(pending)
  );

  // Result side: random stalls, plus a long hold-off each time one is asked for.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst || (job_valid && job_ready) || (result_valid && result_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("nonpreemptive_sjf_scheduler: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_job(input logic [DATA_W-1:0] burst, input logic [DATA_W-1:0] arrival,
                          input logic last);
    while ($urandom_range(0, 99) < send_idle) begin
      job_valid <= 1'b0;
      @(posedge clk);
    end
    job_valid <= 1'b1;
    job <= {burst, arrival, last};
    @(posedge clk);
    while (!job_ready) @(posedge clk);
  endtask

  // Spans are picked per batch so that some batches are full of ties and
  // idle gaps while others use the whole field range.
  task automatic send_batch(int n);
    int burst_span, arr_span;
    case ($urandom_range(0, 2))
      0:       burst_span = 3;
      1:       burst_span = 40;
      default: burst_span = 65535;
    endcase
    case ($urandom_range(0, 3))
      0:       arr_span = 0;
      1:       arr_span = 15;
      2:       arr_span = 300;
      default: arr_span = 65535;
    endcase
    for (int i = 1; i <= n; i++)
      send_job(DATA_W'($urandom_range(0, burst_span)), DATA_W'($urandom_range(0, arr_span)),
               i == n);
  endtask

  task automatic idle_until_drained();
    job_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, bit squeeze);
    int loaded, n, pick;
    send_idle = idle_pct;
    recv_stall <= stall_pct;
    loaded = 0;
    if (squeeze) begin
      // The output is held off while three batches are offered, so the block backs up.
      hold_asked <= hold_asked + 1;
      repeat (3) send_batch(6);
      loaded = 18;
    end
    while (loaded < PHASE_JOBS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) n = $urandom_range(1, 6);
      else if (pick < 80) n = $urandom_range(7, MAX_JOBS - 1);
      else if (pick < 92) n = MAX_JOBS;
      else n = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
      send_batch(n);
      loaded += (n < MAX_JOBS) ? n : MAX_JOBS;
    end
    idle_until_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_job(16'd0, 16'd0, 1'b1);
    // A lone job arriving late makes the schedule jump ahead before it starts.
    send_job(16'hFFFF, 16'hFFFF, 1'b1);
    // Nothing is ready at tick 0, two jobs tie on burst, and a gap precedes the last.
    send_job(16'd7, 16'd20, 1'b0);
    send_job(16'd3, 16'd20, 1'b0);
    send_job(16'd3, 16'd20, 1'b0);
    send_job(16'd1, 16'd100, 1'b1);
    // A full store of the largest jobs; the extra last job is dropped but closes the batch.
    repeat (MAX_JOBS) send_job(16'hFFFF, 16'hFFFF, 1'b0);
    send_job(16'd1, 16'd0, 1'b1);
    idle_until_drained();

    run_phase(0, 0, 1'b1);
    run_phase(54, 0, 1'b0);
    run_phase(0, 54, 1'b0);
    run_phase(34, 34, 1'b0);

    recv_stall <= 0;
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("nonpreemptive_sjf_scheduler: match");
    else
      $display("nonpreemptive_sjf_scheduler: mismatch");
    $finish;
  end

endmodule
